// ===== hdl/tlf_pkg.sv =====
// ----------------------------------------------------------------------------
// tlf_pkg: shared types and constants for the text line folder
// Character codes, register layout and reset values used across the block.
// ----------------------------------------------------------------------------
package tlf_pkg;

    localparam int CHAR_W     = 8;
    localparam int CFG_W      = 6;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
    localparam logic [CHAR_W-1:0] CH_NL    = 8'd10;
    localparam logic [CHAR_W-1:0] CH_BLANK = 8'd32;

    localparam logic [CFG_W-1:0] FOLD_WIDTH_RESET = 6'd10;
    localparam logic [CFG_W-1:0] TAB_WIDTH_RESET  = 6'd8;

    // register index, taken from paddr[2]
    typedef enum logic [0:0] {
        REG_FOLD_WIDTH = 1'b0,
        REG_TAB_WIDTH  = 1'b1
    } reg_idx_t;

endpackage

// ===== hdl/tlf_char_if.sv =====
// ----------------------------------------------------------------------------
// tlf_char_if: input character channel
// Valid/ready channel carrying one text byte per transaction.
// ----------------------------------------------------------------------------
interface tlf_char_if
    import tlf_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] in_char;

    modport source (output valid, output in_char, input ready);
    modport sink   (input valid, input in_char, output ready);
endinterface

// ===== hdl/tlf_line_if.sv =====
// ----------------------------------------------------------------------------
// tlf_line_if: folded output channel
// Valid/ready channel carrying one output byte and its end-of-run flag.
// ----------------------------------------------------------------------------
interface tlf_line_if
    import tlf_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] out_char;
    logic              last_of_run;

    modport source (output valid, output out_char, output last_of_run, input ready);
    modport sink   (input valid, input out_char, input last_of_run, output ready);
endinterface

// ===== hdl/text_line_folder.sv =====
// ----------------------------------------------------------------------------
// text_line_folder: folds a byte stream into lines of bounded length
// text   - sink, one character per transaction (9 = tab, 10 = newline).
// folded - source; last_of_run marks the newline ending one input's output.
// APB    - fold_width at 0x0, tab_width at 0x4; write only while idle.
// One character in flight: text.ready is high only in idle. Handling of each
// accepted character:
//   ordinary byte, no fold        : stored, no output.
//   newline, n bytes buffered     : n + 1 transactions (bytes, then newline).
//   tab                           : finds the stop by repeated subtraction,
//                                   writes a blank at each position up to
//                                   it, and emits the whole line if it fills.
//   fold of a line of len bytes   : backward blank search, emit of the
//                                   bytes before the cut, then the tail
//                                   after the cut is moved to the front.
// Every buffer read goes through the line RAM's single registered read port.
// A one-entry output register holds each transaction; the sequencer waits
// while it is full and folded.ready is low, so stalls stretch the emit.
// Reset empties the line and loads fold_width = 10, tab_width = 8; the
// buffer is not cleared, as only written slots are read.
// ----------------------------------------------------------------------------
module text_line_folder
    import tlf_pkg::*;
#(
    parameter int BUF_DEPTH = 32
)(
    input  logic                  clk,
    input  logic                  rst_n,
    tlf_char_if.sink              text,
    tlf_line_if.source            folded,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);
    // count width holds 0..BUF_DEPTH, address width indexes the buffer
    localparam int CW = $clog2(BUF_DEPTH + 1);
    localparam int AW = $clog2(BUF_DEPTH);
    localparam logic [CW-1:0] LAST_POS = CW'(BUF_DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_C  = CW'(BUF_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_TAB_MOD,
        S_TAB_FILL,
        S_SEARCH,
        S_EMIT,
        S_NEWLINE,
        S_COPY
    } state_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] fold_width_reg;
    logic [CFG_W-1:0] tab_width_reg;
    reg_idx_t         cfg_idx;

    assign cfg_idx = reg_idx_t'(paddr[2]);
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fold_width_reg <= FOLD_WIDTH_RESET;
            tab_width_reg  <= TAB_WIDTH_RESET;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (cfg_idx)
                REG_FOLD_WIDTH: fold_width_reg <= pwdata[CFG_W-1:0];
                REG_TAB_WIDTH:  tab_width_reg  <= pwdata[CFG_W-1:0];
                default:        fold_width_reg <= fold_width_reg;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_FOLD_WIDTH: prdata = APB_DATA_W'(fold_width_reg);
            REG_TAB_WIDTH:  prdata = APB_DATA_W'(tab_width_reg);
            default:        prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer state
    // ------------------------------------------------------------------
    state_t            state_reg,    state_next;
    logic [CW-1:0]     fill_reg,     fill_next;     // buffered characters
    logic [CW-1:0]     len_reg,      len_next;      // line length / tab position
    logic [CW-1:0]     cut_reg,      cut_next;      // characters to emit
    logic [CW-1:0]     ptr_reg,      ptr_next;      // search / emit / copy source
    logic [CW-1:0]     pk_reg,       pk_next;       // cut candidate of pending read
    logic [CW-1:0]     q_reg,        q_next;        // copy destination
    logic [CFG_W-1:0]  m_reg,        m_next;        // column modulo tab width
    logic              pend_reg,     pend_next;     // read issued last cycle
    logic              ok_reg,       ok_next;       // rdata holds buffer[ptr]
    logic              fold_reg,     fold_next;     // emit is a fold, tail moves
    logic              out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0] out_char_reg, out_char_next;
    logic              out_last_reg, out_last_next;

    // effective widths
    logic [CW-1:0]    w_eff;
    logic [CFG_W-1:0] t_eff;
    logic [CW-1:0]    i_cur;
    logic [CW-1:0]    i_inc;
    logic [CW-1:0]    pos_inc;
    logic [CFG_W-1:0] m_inc;
    logic             out_free;

    // buffer RAM controls
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [CHAR_W-1:0] ram_wdata;
    logic [CW-1:0]     rd_ptr;
    logic [CHAR_W-1:0] ram_rdata;

    always_comb
    begin
        if (fold_width_reg < CFG_W'(2))
            w_eff = CW'(2);
        else if (int'(fold_width_reg) > BUF_DEPTH)
            w_eff = DEPTH_C;
        else
            w_eff = CW'(fold_width_reg);
    end

    assign t_eff    = (tab_width_reg == '0) ? CFG_W'(1) : tab_width_reg;
    assign i_cur    = (fill_reg > LAST_POS) ? LAST_POS : fill_reg;
    assign i_inc    = i_cur + CW'(1);
    assign pos_inc  = len_reg + CW'(1);
    assign m_inc    = ((m_reg + CFG_W'(1)) == t_eff) ? '0 : m_reg + CFG_W'(1);
    assign out_free = !out_valid_reg || folded.ready;

    assign text.ready         = (state_reg == S_IDLE);
    assign folded.valid       = out_valid_reg;
    assign folded.out_char    = out_char_reg;
    assign folded.last_of_run = out_last_reg;

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        len_next       = len_reg;
        cut_next       = cut_reg;
        ptr_next       = ptr_reg;
        pk_next        = pk_reg;
        q_next         = q_reg;
        m_next         = m_reg;
        pend_next      = pend_reg;
        ok_next        = ok_reg;
        fold_next      = fold_reg;
        out_valid_next = out_valid_reg && !folded.ready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        ram_we         = 1'b0;
        ram_waddr      = i_cur[AW-1:0];
        ram_wdata      = text.in_char;
        rd_ptr         = ptr_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (text.valid)
                begin
                    case (text.in_char)
                        CH_TAB:
                        begin
                            if (i_cur < w_eff)
                            begin
                                len_next   = i_cur;
                                m_next     = CFG_W'(i_cur);
                                state_next = S_TAB_MOD;
                            end
                            else
                            begin
                                // line already full: emit it as is
                                cut_next   = i_cur;
                                fold_next  = 1'b0;
                                ptr_next   = '0;
                                ok_next    = 1'b0;
                                state_next = S_EMIT;
                            end
                        end
                        CH_NL:
                        begin
                            cut_next   = i_cur;
                            fold_next  = 1'b0;
                            ptr_next   = '0;
                            ok_next    = 1'b0;
                            state_next = S_EMIT;
                        end
                        default:
                        begin
                            ram_we = 1'b1;
                            if (i_inc >= w_eff)
                            begin
                                len_next   = i_inc;
                                ptr_next   = i_inc;
                                pend_next  = 1'b0;
                                state_next = S_SEARCH;
                            end
                            else
                            begin
                                fill_next = i_inc;
                            end
                        end
                    endcase
                end
            end

            // column mod tab width by repeated subtraction
            S_TAB_MOD:
            begin
                if (m_reg >= t_eff)
                    m_next = m_reg - t_eff;
                else
                    state_next = S_TAB_FILL;
            end

            // one blank per cycle up to the next stop or the fold width
            S_TAB_FILL:
            begin
                ram_we    = 1'b1;
                ram_waddr = len_reg[AW-1:0];
                ram_wdata = CH_BLANK;
                len_next  = pos_inc;
                m_next    = m_inc;
                if (pos_inc < w_eff)
                begin
                    if (m_inc == '0)
                    begin
                        fill_next  = pos_inc;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    cut_next   = pos_inc;
                    fold_next  = 1'b0;
                    ptr_next   = '0;
                    ok_next    = 1'b0;
                    state_next = S_EMIT;
                end
            end

            // backward scan for the last blank, one read per cycle
            S_SEARCH:
            begin
                if (pend_reg && (ram_rdata == CH_BLANK))
                begin
                    cut_next   = pk_reg;
                    fold_next  = 1'b1;
                    ptr_next   = '0;
                    ok_next    = 1'b0;
                    state_next = S_EMIT;
                end
                else if (ptr_reg == '0)
                begin
                    cut_next   = len_reg;
                    fold_next  = 1'b1;
                    ptr_next   = '0;
                    ok_next    = 1'b0;
                    state_next = S_EMIT;
                end
                else
                begin
                    rd_ptr    = ptr_reg - CW'(1);
                    ptr_next  = ptr_reg - CW'(1);
                    pk_next   = ptr_reg;
                    pend_next = 1'b1;
                end
            end

            // stream buffer[0 .. cut-1]; read runs one address ahead
            S_EMIT:
            begin
                ok_next = 1'b1;
                if (ptr_reg == cut_reg)
                begin
                    state_next = S_NEWLINE;
                end
                else if (ok_reg && out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = ram_rdata;
                    out_last_next  = 1'b0;
                    rd_ptr         = ptr_reg + CW'(1);
                    ptr_next       = ptr_reg + CW'(1);
                end
            end

            S_NEWLINE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = CH_NL;
                    out_last_next  = 1'b1;
                    if (fold_reg)
                    begin
                        ptr_next   = cut_reg;
                        q_next     = '0;
                        pend_next  = 1'b0;
                        state_next = S_COPY;
                    end
                    else
                    begin
                        fill_next  = '0;
                        state_next = S_IDLE;
                    end
                end
            end

            // move the tail after the cut to the front
            S_COPY:
            begin
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = q_reg[AW-1:0];
                    ram_wdata = ram_rdata;
                    q_next    = q_reg + CW'(1);
                end
                if (ptr_reg < len_reg)
                begin
                    rd_ptr    = ptr_reg;
                    ptr_next  = ptr_reg + CW'(1);
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        fill_next  = q_reg;
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            len_reg       <= '0;
            cut_reg       <= '0;
            ptr_reg       <= '0;
            pk_reg        <= '0;
            q_reg         <= '0;
            m_reg         <= '0;
            pend_reg      <= 1'b0;
            ok_reg        <= 1'b0;
            fold_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_char_reg  <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            len_reg       <= len_next;
            cut_reg       <= cut_next;
            ptr_reg       <= ptr_next;
            pk_reg        <= pk_next;
            q_reg         <= q_next;
            m_reg         <= m_next;
            pend_reg      <= pend_next;
            ok_reg        <= ok_next;
            fold_reg      <= fold_next;
            out_valid_reg <= out_valid_next;
            out_char_reg  <= out_char_next;
            out_last_reg  <= out_last_next;
        end
    end

    // ------------------------------------------------------------------
    // Line buffer
    // ------------------------------------------------------------------
    tlf_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (BUF_DEPTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_ptr[AW-1:0]),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= LAST_POS)
        else $error("fill count beyond buffer");

    a_last_is_newline: assert property (@(posedge clk) disable iff (!rst_n)
        folded.valid && folded.last_of_run |-> folded.out_char == CH_NL)
        else $error("end of run not on newline");

    a_copy_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_COPY |-> q_reg < ptr_reg || (q_reg == '0 && ptr_reg == '0))
        else $error("tail move overlaps its source");

    a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMIT |-> ptr_reg <= cut_reg)
        else $error("emit pointer past cut");

endmodule

// ===== hdl/tlf_ram.sv =====
// ----------------------------------------------------------------------------
// tlf_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tlf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
)(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end
endmodule
